FILE: design/idp_pkg.sv
// Shared types and constants for the ID pool allocator.
// No dependencies; every other design file but idp_ram refers to this package by scoped name.
package idp_pkg;

   // Fixed field widths
   localparam int ID_W     = 32;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 11;
   localparam int COUNT_W  = 11;

   // Saturation value of the used counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

   // Configuration port layout: two 32-bit registers at byte offsets 0 and 4
   localparam int ADDR_W = 3;
   localparam logic REG_BASE_ID   = 1'b0;
   localparam logic REG_POOL_SIZE = 1'b1;

   // Reset values of the registers
   localparam logic [ID_W-1:0]   BASE_ID_RST   = 32'd0;
   localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 11'd1024;

   // Depth of the command queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // Operation codes
   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_SET   = 2'd2,
      KIND_GET   = 2'd3
   } idp_kind_type;

   // Classified command handed from the front end to the back end
   typedef struct packed {
      idp_kind_type        kind;
      logic                ok;      // named ID lies inside the pool
      logic [ID_W-1:0]     idx;     // req_id minus base_id, modulo 2^32
      logic [HANDLE_W-1:0] handle;
   } idp_cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_ALLOC_FIX,
      ST_FREE_LINK,
      ST_FREE_HEAD
   } idp_state_type;

endpackage

FILE: design/idp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module idp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/idp_front.sv
// Front end of the ID pool allocator: accepts request beats and classifies them.
// Depends on idp_pkg for the command type and field widths.
module idp_front (
   input  logic                               req_valid,
   input  logic [1:0]                         req_kind,
   input  logic [idp_pkg::ID_W-1:0]           req_id,
   input  logic [idp_pkg::HANDLE_W-1:0]       req_handle_in,
   input  logic [idp_pkg::ID_W-1:0]           base_id,
   input  logic [idp_pkg::SIZE_W-1:0]         eff_size,
   input  logic                               queue_full,
   input  logic                               init_busy,
   output logic                               req_stall,
   output logic                               push,
   output idp_pkg::idp_cmd_type               cmd
);

   logic [idp_pkg::ID_W-1:0] diff;
   logic                     in_range;

   // Hold off while the queue is full or the tables are being initialised.
   assign req_stall = queue_full | init_busy;
   assign push      = req_valid & ~req_stall;

   // An ID is usable when it is nonzero and maps to a nonzero index below the pool size.
   assign diff     = req_id - base_id;
   assign in_range = diff < {{(idp_pkg::ID_W - idp_pkg::SIZE_W){1'b0}}, eff_size};

   always_comb begin
      cmd.kind   = idp_pkg::idp_kind_type'(req_kind);
      cmd.ok     = (req_id != '0) && (diff != '0) && in_range;
      cmd.idx    = diff;
      cmd.handle = req_handle_in;
   end

endmodule

FILE: design/idp_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on idp_pkg for the command type and queue depth.
module idp_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  idp_pkg::idp_cmd_type  cmd_in,
   input  logic                  pop,
   output idp_pkg::idp_cmd_type  cmd_out,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PW = $clog2(idp_pkg::QUEUE_DEPTH);

   idp_pkg::idp_cmd_type entry_ff [idp_pkg::QUEUE_DEPTH];
   logic [PW-1:0]        wptr_ff;
   logic [PW-1:0]        wptr_in;
   logic [PW-1:0]        rptr_ff;
   logic [PW-1:0]        rptr_in;
   logic [PW:0]          fill_ff;
   logic [PW:0]          fill_in;

   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == (PW+1)'(idp_pkg::QUEUE_DEPTH));
   assign cmd_out   = entry_ff[rptr_ff];

   // Pointer and fill level updates
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= cmd_in;
      end
   end

endmodule

FILE: design/idp_back.sv
// Back end of the ID pool allocator: link tables, handle store and the sequencer
// that carries out each command. Depends on idp_pkg and idp_ram.
module idp_back #(
   parameter int NUM_SLOTS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               init_req,
   input  logic [idp_pkg::ID_W-1:0]           base_id,
   input  logic [idp_pkg::SIZE_W-1:0]         eff_size,
   input  idp_pkg::idp_cmd_type               cmd,
   input  logic                               cmd_valid,
   output logic                               cmd_pop,
   output logic                               init_busy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [idp_pkg::ID_W-1:0]           rsp_granted_id,
   output logic [idp_pkg::HANDLE_W-1:0]       rsp_handle_out,
   output logic                               rsp_id_valid,
   output logic [idp_pkg::COUNT_W-1:0]        rsp_used_count
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = (IW + 1 > idp_pkg::SIZE_W) ? IW + 1 : idp_pkg::SIZE_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

   idp_pkg::idp_state_type state_ff, state_in;
   idp_pkg::idp_cmd_type   cur_ff, cur_in;
   logic [IW-1:0]                  sweep_ff, sweep_in;
   logic [IW-1:0]                  head_ff, head_in;
   logic [idp_pkg::COUNT_W-1:0]    count_ff, count_in;

   logic                           rsp_valid_ff;
   logic [idp_pkg::ID_W-1:0]       granted_ff, granted_in;
   logic [idp_pkg::HANDLE_W-1:0]   hout_ff, hout_in;
   logic                           valid_ff, valid_in;
   logic [idp_pkg::COUNT_W-1:0]    used_ff, used_in;
   logic                           rsp_load;
   logic                           out_free;

   // Memory ports
   logic [IW-1:0]                  rd_addr;
   logic                           next_we, prev_we, flag_we, hdl_we;
   logic [IW-1:0]                  next_wa, prev_wa, flag_wa, hdl_wa;
   logic [IW-1:0]                  next_wd, prev_wd;
   logic                           flag_wd;
   logic [idp_pkg::HANDLE_W-1:0]   hdl_wd;
   logic [IW-1:0]                  next_rd, prev_rd;
   logic                           flag_rd;
   logic [idp_pkg::HANDLE_W-1:0]   hdl_rd;

   // Helpers
   logic [IW-1:0]                  cur_idx;
   logic [CW-1:0]                  sweep_w, size_w;
   logic                           sweep_in_pool;
   logic [idp_pkg::COUNT_W-1:0]    count_inc, count_dec;

   assign cur_idx       = cur_ff.idx[IW-1:0];
   assign sweep_w       = CW'(sweep_ff);
   assign size_w        = CW'(eff_size);
   assign sweep_in_pool = (sweep_w != '0) && (sweep_w < size_w);
   assign count_inc     = (count_ff != idp_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign count_dec     = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
   assign out_free      = ~rsp_valid_ff | ~rsp_stall;
   assign init_busy     = (state_ff == idp_pkg::ST_INIT);

   // Link tables, free flags and handle store
   idp_ram #(.WIDTH(IW), .DEPTH(NUM_SLOTS)) u_next_ram (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(rd_addr), .rdata(next_rd)
   );
   idp_ram #(.WIDTH(IW), .DEPTH(NUM_SLOTS)) u_prev_ram (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .raddr(rd_addr), .rdata(prev_rd)
   );
   idp_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_flag_ram (
      .clock(clock), .we(flag_we), .waddr(flag_wa), .wdata(flag_wd),
      .raddr(rd_addr), .rdata(flag_rd)
   );
   idp_ram #(.WIDTH(idp_pkg::HANDLE_W), .DEPTH(NUM_SLOTS)) u_handle_ram (
      .clock(clock), .we(hdl_we), .waddr(hdl_wa), .wdata(hdl_wd),
      .raddr(rd_addr), .rdata(hdl_rd)
   );

   // Next-state logic of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idp_pkg::ST_INIT: begin
            if (sweep_ff == LAST_IDX) begin
               state_in = idp_pkg::ST_IDLE;
            end
         end
         idp_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               state_in = idp_pkg::ST_EXEC;
            end
         end
         idp_pkg::ST_EXEC: begin
            state_in = idp_pkg::ST_IDLE;
            if (cur_ff.kind == idp_pkg::KIND_ALLOC) begin
               if (head_ff != '0 && next_rd != '0) begin
                  state_in = idp_pkg::ST_ALLOC_FIX;
               end
            end else if (cur_ff.kind == idp_pkg::KIND_FREE && cur_ff.ok) begin
               state_in = idp_pkg::ST_FREE_LINK;
            end
         end
         idp_pkg::ST_ALLOC_FIX: state_in = idp_pkg::ST_IDLE;
         idp_pkg::ST_FREE_LINK: state_in = idp_pkg::ST_FREE_HEAD;
         idp_pkg::ST_FREE_HEAD: state_in = idp_pkg::ST_IDLE;
         default:               state_in = idp_pkg::ST_INIT;
      endcase
      // A register write rebuilds the whole pool.
      if (init_req) begin
         state_in = idp_pkg::ST_INIT;
      end
   end

   // Datapath and memory controls of the sequencer
   always_comb begin
      cmd_pop    = 1'b0;
      cur_in     = cur_ff;
      sweep_in   = sweep_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      rd_addr    = head_ff;
      rsp_load   = 1'b0;
      granted_in = '0;
      hout_in    = '0;
      valid_in   = 1'b0;
      used_in    = count_ff;
      next_we    = 1'b0;
      next_wa    = cur_idx;
      next_wd    = '0;
      prev_we    = 1'b0;
      prev_wa    = cur_idx;
      prev_wd    = '0;
      flag_we    = 1'b0;
      flag_wa    = cur_idx;
      flag_wd    = 1'b0;
      hdl_we     = 1'b0;
      hdl_wa     = cur_idx;
      hdl_wd     = '0;

      case (state_ff)
         // Sweep every slot: descending next chain, ascending prev chain, all handles zero.
         idp_pkg::ST_INIT: begin
            next_we  = 1'b1;
            next_wa  = sweep_ff;
            next_wd  = sweep_in_pool ? sweep_ff - 1'b1 : '0;
            prev_we  = 1'b1;
            prev_wa  = sweep_ff;
            prev_wd  = (sweep_in_pool && (sweep_w + 1'b1 < size_w)) ? sweep_ff + 1'b1 : '0;
            flag_we  = 1'b1;
            flag_wa  = sweep_ff;
            flag_wd  = sweep_in_pool;
            hdl_we   = 1'b1;
            hdl_wa   = sweep_ff;
            hdl_wd   = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               head_in  = (size_w > CW'(1)) ? IW'(eff_size - 1'b1) : '0;
               count_in = '0;
            end
         end

         // Take the next command and read its slot (the list head for allocate).
         idp_pkg::ST_IDLE: begin
            rd_addr = (cmd.kind == idp_pkg::KIND_ALLOC) ? head_ff : cmd.idx[IW-1:0];
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
            end
         end

         idp_pkg::ST_EXEC: begin
            rsp_load = 1'b1;
            case (cur_ff.kind)
               // Pop the head and detach it.
               idp_pkg::KIND_ALLOC: begin
                  if (head_ff != '0) begin
                     next_we    = 1'b1;
                     next_wa    = head_ff;
                     prev_we    = 1'b1;
                     prev_wa    = head_ff;
                     flag_we    = 1'b1;
                     flag_wa    = head_ff;
                     head_in    = next_rd;
                     count_in   = count_inc;
                     granted_in = base_id + idp_pkg::ID_W'(head_ff);
                     valid_in   = 1'b1;
                     used_in    = count_inc;
                  end
               end
               // Clear the handle and unlink the entry if it sits on the list.
               idp_pkg::KIND_FREE: begin
                  if (cur_ff.ok) begin
                     rsp_load = 1'b0;
                     hdl_we   = 1'b1;
                     if (flag_rd) begin
                        if (prev_rd != '0) begin
                           next_we = 1'b1;
                           next_wa = prev_rd;
                           next_wd = next_rd;
                        end else begin
                           head_in = next_rd;
                        end
                        if (next_rd != '0) begin
                           prev_we = 1'b1;
                           prev_wa = next_rd;
                           prev_wd = prev_rd;
                        end
                     end
                  end
               end
               idp_pkg::KIND_SET: begin
                  if (cur_ff.ok) begin
                     hdl_we   = 1'b1;
                     hdl_wd   = cur_ff.handle;
                     valid_in = 1'b1;
                  end
               end
               idp_pkg::KIND_GET: begin
                  if (cur_ff.ok) begin
                     hout_in  = hdl_rd;
                     valid_in = 1'b1;
                  end
               end
               default: begin
                  valid_in = 1'b0;
               end
            endcase
         end

         // The new head after an allocate loses its back link.
         idp_pkg::ST_ALLOC_FIX: begin
            prev_we = 1'b1;
            prev_wa = head_ff;
            prev_wd = '0;
         end

         // Point the freed entry at the current head and mark it free.
         idp_pkg::ST_FREE_LINK: begin
            next_we = 1'b1;
            next_wd = head_ff;
            prev_we = 1'b1;
            flag_we = 1'b1;
            flag_wd = 1'b1;
         end

         // Hook the old head back to the freed entry and make it the new head.
         idp_pkg::ST_FREE_HEAD: begin
            if (head_ff != '0) begin
               prev_we = 1'b1;
               prev_wa = head_ff;
               prev_wd = cur_idx;
            end
            head_in  = cur_idx;
            count_in = count_dec;
            rsp_load = 1'b1;
            valid_in = 1'b1;
            used_in  = count_dec;
         end

         default: begin
            cmd_pop = 1'b0;
         end
      endcase

      if (init_req) begin
         sweep_in = '0;
      end
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idp_pkg::ST_INIT;
         sweep_ff <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Result register: holds a beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         granted_ff <= granted_in;
         hout_ff    <= hout_in;
         valid_ff   <= valid_in;
         used_ff    <= used_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = granted_ff;
   assign rsp_handle_out = hout_ff;
   assign rsp_id_valid   = valid_ff;
   assign rsp_used_count = used_ff;

endmodule

FILE: design/id_pool_allocator.sv
// Top level of the ID pool allocator: register block, front end, queue and back end.
// Depends on idp_pkg, idp_front, idp_cmd_queue, idp_back and idp_ram.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_kind, req_id, req_handle_in
//   rsp       out         rsp_valid/rsp_stall  rsp_granted_id, rsp_handle_out,
//                                              rsp_id_valid, rsp_used_count
//   csr       in          psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// The back-end sequencer passes every request through ST_IDLE and ST_EXEC; an allocate that
// leaves a non-empty list adds ST_ALLOC_FIX and a valid free adds ST_FREE_LINK and
// ST_FREE_HEAD, since each link table has a single write port. Two requests can wait in
// the queue. After reset and after every register write the tables are initialised slot
// by slot, with req_stall held high. A stalled result holds the back end after its
// current request, while the front end keeps filling the queue.
module id_pool_allocator #(
   parameter int NUM_SLOTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [idp_pkg::ID_W-1:0]            req_id,
   input  logic [idp_pkg::HANDLE_W-1:0]        req_handle_in,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [idp_pkg::ID_W-1:0]            rsp_granted_id,
   output logic [idp_pkg::HANDLE_W-1:0]        rsp_handle_out,
   output logic                                rsp_id_valid,
   output logic [idp_pkg::COUNT_W-1:0]         rsp_used_count,
   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [idp_pkg::ADDR_W-1:0]          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [idp_pkg::ID_W-1:0]   base_id_ff;
   logic [idp_pkg::ID_W-1:0]   base_id_in;
   logic [idp_pkg::SIZE_W-1:0] pool_size_ff;
   logic [idp_pkg::SIZE_W-1:0] pool_size_in;
   logic [idp_pkg::SIZE_W-1:0] eff_size;
   logic                       cfg_wr;
   logic                       reg_sel;

   idp_pkg::idp_cmd_type       front_cmd;
   idp_pkg::idp_cmd_type       queue_cmd;
   logic                       push;
   logic                       pop;
   logic                       queue_full;
   logic                       queue_not_empty;
   logic                       init_busy;

   // Register block
   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   always_comb begin
      base_id_in   = base_id_ff;
      pool_size_in = pool_size_ff;
      prdata       = '0;
      case (reg_sel)
         idp_pkg::REG_BASE_ID: begin
            prdata = base_id_ff;
            if (cfg_wr) begin
               base_id_in = pwdata;
            end
         end
         idp_pkg::REG_POOL_SIZE: begin
            prdata = {{(32 - idp_pkg::SIZE_W){1'b0}}, pool_size_ff};
            if (cfg_wr) begin
               pool_size_in = pwdata[idp_pkg::SIZE_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff   <= idp_pkg::BASE_ID_RST;
         pool_size_ff <= idp_pkg::POOL_SIZE_RST;
      end else begin
         base_id_ff   <= base_id_in;
         pool_size_ff <= pool_size_in;
      end
   end

   // Pool size in use is clamped to the table depth.
   always_comb begin
      if (32'(pool_size_ff) > NUM_SLOTS) begin
         eff_size = idp_pkg::SIZE_W'(NUM_SLOTS);
      end else begin
         eff_size = pool_size_ff;
      end
   end

   idp_front u_front (
      .req_valid    (req_valid),
      .req_kind     (req_kind),
      .req_id       (req_id),
      .req_handle_in(req_handle_in),
      .base_id      (base_id_ff),
      .eff_size     (eff_size),
      .queue_full   (queue_full),
      .init_busy    (init_busy),
      .req_stall    (req_stall),
      .push         (push),
      .cmd          (front_cmd)
   );

   idp_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .cmd_in   (front_cmd),
      .pop      (pop),
      .cmd_out  (queue_cmd),
      .not_empty(queue_not_empty),
      .full     (queue_full)
   );

   idp_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .init_req      (cfg_wr),
      .base_id       (base_id_ff),
      .eff_size      (eff_size),
      .cmd           (queue_cmd),
      .cmd_valid     (queue_not_empty),
      .cmd_pop       (pop),
      .init_busy     (init_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_granted_id(rsp_granted_id),
      .rsp_handle_out(rsp_handle_out),
      .rsp_id_valid  (rsp_id_valid),
      .rsp_used_count(rsp_used_count)
   );

   // A register write starts a rebuild, so no request may be taken on the next cycle.
   a_cfg_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> req_stall)
      else $error("request channel open right after a register write");

   // The used count can never reach the number of table slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_used_count) < NUM_SLOTS))
      else $error("used count beyond pool capacity");

   // A nonzero granted ID or handle only comes with a valid ID.
   a_payload_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_granted_id != '0 || rsp_handle_out != '0)) |-> rsp_id_valid)
      else $error("granted ID or handle returned without a valid ID");

endmodule

FILE: tb/sv/idp_pool_checker.sv
// Checker for the ID pool allocator: watches the request, result and register ports,
// keeps its own model of the free list and handle table, and compares every result beat.
// Depends on idp_pkg for field widths, register addresses and operation codes.
module idp_pool_checker
   import idp_pkg::*;
#(
   parameter int NUM_SLOTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_kind,
   input  logic [ID_W-1:0]        req_id,
   input  logic [HANDLE_W-1:0]    req_handle_in,
   // Result channel
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [ID_W-1:0]        rsp_granted_id,
   input  logic [HANDLE_W-1:0]    rsp_handle_out,
   input  logic                   rsp_id_valid,
   input  logic [COUNT_W-1:0]     rsp_used_count,
   // Configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [ADDR_W-1:0]      paddr,
   input  logic [31:0]            pwdata,
   input  logic                   pready,
   // Status towards the testbench top
   output int unsigned            fail_count,
   output int unsigned            outstanding,
   output int unsigned            beats_checked,
   output int unsigned            grants,
   output int unsigned            empty_denials,
   output int unsigned            invalid_ids,
   output int unsigned            settings_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = $clog2(NUM_SLOTS);

   // One result beat as the block should present it.
   typedef struct packed {
      logic [ID_W-1:0]     granted;
      logic [HANDLE_W-1:0] handle;
      logic                valid;
      logic [COUNT_W-1:0]  count;
   } pool_answer_type;

   // Model copy of the registers and of the pool state.
   logic [ID_W-1:0]     cfg_base;
   logic [SIZE_W-1:0]   cfg_size;
   logic [IDX_W-1:0]    link_next [NUM_SLOTS];
   logic [IDX_W-1:0]    link_prev [NUM_SLOTS];
   logic                on_list   [NUM_SLOTS];
   logic [HANDLE_W-1:0] handles   [NUM_SLOTS];
   logic [IDX_W-1:0]    head;
   logic [COUNT_W-1:0]  used;

   pool_answer_type answers_due[$];
   int unsigned     mismatches = 0;

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      beats_checked = 0;
      grants        = 0;
      empty_denials = 0;
      invalid_ids   = 0;
      settings_seen = 0;
   end

   // Number of slots actually in use; a size of zero behaves like one.
   function automatic int unsigned live_size();
      if (cfg_size > NUM_SLOTS)
         return NUM_SLOTS;
      return cfg_size;
   endfunction

   // Puts the pool back into its initial state for the current register values.
   function automatic void rebuild_pool();
      int unsigned n;
      n = live_size();
      head = '0;
      used = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         link_next[i] = '0;
         link_prev[i] = '0;
         on_list[i]   = 1'b0;
         handles[i]   = '0;
      end
      for (int unsigned i = 1; i < n; i++) begin
         link_next[i] = IDX_W'(i - 1);
         link_prev[i] = (i + 1 < n) ? IDX_W'(i + 1) : '0;
         on_list[i]   = 1'b1;
      end
      if (n > 1)
         head = IDX_W'(n - 1);
   endfunction

   // Applies one request beat to the model and returns the answer it should produce.
   function automatic pool_answer_type predict_op(idp_kind_type op, logic [ID_W-1:0] id,
                                                  logic [HANDLE_W-1:0] hin);
      pool_answer_type  ans;
      logic [ID_W-1:0]  offset;
      logic [IDX_W-1:0] idx, e, p, nx;
      logic             ok;
      ans    = '0;
      offset = id - cfg_base;
      ok     = (id != 0) && (offset != 0) && (offset < live_size());
      idx    = offset[IDX_W-1:0];
      if (op == KIND_ALLOC) begin
         // Pop the head of the free list, if there is one.
         if (head != 0) begin
            e  = head;
            nx = link_next[e];
            head = nx;
            if (nx != 0)
               link_prev[nx] = '0;
            link_next[e] = '0;
            link_prev[e] = '0;
            on_list[e]   = 1'b0;
            if (used != COUNT_MAX)
               used = used + 1'b1;
            ans.granted = cfg_base + ID_W'(e);
            ans.valid   = 1'b1;
         end
      end else if (ok) begin
         ans.valid = 1'b1;
         case (op)
            KIND_FREE: begin
               // Unlink wherever it sits, then push it at the head.
               handles[idx] = '0;
               if (on_list[idx]) begin
                  p  = link_prev[idx];
                  nx = link_next[idx];
                  if (p != 0)
                     link_next[p] = nx;
                  else
                     head = nx;
                  if (nx != 0)
                     link_prev[nx] = p;
               end
               link_next[idx] = head;
               link_prev[idx] = '0;
               if (head != 0)
                  link_prev[head] = idx;
               head = idx;
               on_list[idx] = 1'b1;
               if (used != 0)
                  used = used - 1'b1;
            end
            KIND_SET: handles[idx] = hin;
            default:  ans.handle = handles[idx];
         endcase
      end
      ans.count = used;
      return ans;
   endfunction

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch on result beat %0d, %s: got 0x%08h, expected 0x%08h",
               $realtime, beats_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      pool_answer_type want;
      if (reset) begin
         cfg_base = BASE_ID_RST;
         cfg_size = POOL_SIZE_RST;
         rebuild_pool();
         answers_due.delete();
      end else begin
         // A register write re-initialises the whole pool.
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_W'({REG_BASE_ID, 2'b00})) begin
               cfg_base = pwdata;
               rebuild_pool();
               settings_seen++;
            end else if (paddr == ADDR_W'({REG_POOL_SIZE, 2'b00})) begin
               cfg_size = pwdata[SIZE_W-1:0];
               rebuild_pool();
               settings_seen++;
            end
         end

         // Each accepted request beat yields exactly one expected result.
         if (req_valid && !req_stall) begin
            want = predict_op(idp_kind_type'(req_kind), req_id, req_handle_in);
            answers_due.push_back(want);
            if (idp_kind_type'(req_kind) == KIND_ALLOC) begin
               if (want.valid)
                  grants++;
               else
                  empty_denials++;
            end else if (!want.valid) begin
               invalid_ids++;
            end
         end

         // Compare each accepted result beat with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_granted_id, '0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_granted_id !== want.granted)
                  report_mismatch("granted_id", rsp_granted_id, want.granted);
               if (rsp_handle_out !== want.handle)
                  report_mismatch("handle_out", rsp_handle_out, want.handle);
               if (rsp_id_valid !== want.valid)
                  report_mismatch("id_valid", 32'(rsp_id_valid), 32'(want.valid));
               if (rsp_used_count !== want.count)
                  report_mismatch("used_count", 32'(rsp_used_count), 32'(want.count));
            end
            beats_checked++;
         end
      end
      fail_count  <= mismatches;
      outstanding <= answers_due.size();
   end

endmodule

FILE: tb/sv/id_pool_allocator_tb.sv
// Testbench top for the ID pool allocator: clock, reset, request and register stimulus,
// result-side stalling and the final verdict. Depends on idp_pkg, idp_pool_checker
// and the id_pool_allocator design.
module id_pool_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import idp_pkg::*;

   localparam int NUM_SLOTS   = 1024;
   localparam int HOLD_CYCLES = 120;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_kind = KIND_ALLOC;
   logic [ID_W-1:0]     req_id = '0;
   logic [HANDLE_W-1:0] req_handle_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ID_W-1:0]     rsp_granted_id;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic                rsp_id_valid;
   logic [COUNT_W-1:0]  rsp_used_count;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   int unsigned fail_count, outstanding, beats_checked;
   int unsigned grants, empty_denials, invalid_ids, settings_seen;

   // Stimulus-side copy of the registers, used only to aim IDs at the pool.
   logic [ID_W-1:0]   cur_base = BASE_ID_RST;
   logic [SIZE_W-1:0] cur_size = POOL_SIZE_RST;

   // Long result hold-off: requested by the stimulus, timed by the result side.
   logic hold_go = 1'b0;
   logic hold_active = 1'b0;

   id_pool_allocator #(.NUM_SLOTS(NUM_SLOTS)) DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind, .req_id, .req_handle_in,
      .rsp_valid, .rsp_stall, .rsp_granted_id, .rsp_handle_out, .rsp_id_valid,
      .rsp_used_count,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   idp_pool_checker #(.NUM_SLOTS(NUM_SLOTS)) pool_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind, .req_id, .req_handle_in,
      .rsp_valid, .rsp_stall, .rsp_granted_id, .rsp_handle_out, .rsp_id_valid,
      .rsp_used_count,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .outstanding, .beats_checked, .grants, .empty_denials,
      .invalid_ids, .settings_seen
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one request beat and returns at the edge where it is taken.
   task automatic offer_request(idp_kind_type op, logic [ID_W-1:0] id,
                                logic [HANDLE_W-1:0] hin);
      req_valid     <= 1'b1;
      req_kind      <= op;
      req_id        <= id;
      req_handle_in <= hin;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stops offering and waits until every expected result beat has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Register write: setup phase, then access phase until pready.
   task automatic csr_write(logic reg_sel, logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'({reg_sel, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_pool(logic [ID_W-1:0] base, logic [SIZE_W-1:0] size);
      drain_results();
      csr_write(REG_BASE_ID, base);
      csr_write(REG_POOL_SIZE, 32'(size));
      cur_base = base;
      cur_size = size;
   endtask

   function automatic idp_kind_type pick_kind(int unsigned alloc_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < alloc_pct)
         return KIND_ALLOC;
      r = $urandom_range(0, 9);
      if (r < 4)
         return KIND_FREE;
      if (r < 7)
         return KIND_SET;
      return KIND_GET;
   endfunction

   // Mostly IDs near the top of the pool, where allocations land, plus the awkward ones.
   function automatic logic [ID_W-1:0] pick_id();
      int unsigned eff, span, sel;
      eff  = (cur_size > NUM_SLOTS) ? NUM_SLOTS : ((cur_size == 0) ? 1 : cur_size);
      span = (eff - 1 < 12) ? eff - 1 : 12;
      sel  = $urandom_range(0, 99);
      if (sel < 55)
         return cur_base + ID_W'(eff - 1 - $urandom_range(0, span));
      if (sel < 75)
         return cur_base + ID_W'($urandom_range(0, eff + 1));
      if (sel < 82)
         return '0;
      if (sel < 88)
         return cur_base - ID_W'($urandom_range(1, 4));
      if (sel < 94)
         return cur_base + ID_W'(eff + $urandom_range(0, 3));
      return $urandom;
   endfunction

   // One pool setting: new registers, then random bursts separated by random gaps.
   task automatic run_phase(logic [ID_W-1:0] base, logic [SIZE_W-1:0] size,
                            int unsigned n_items, int unsigned alloc_pct, bit with_hold);
      int unsigned sent, burst, gap, bias;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      set_pool(base, size);
      if (with_hold) begin
         // Let the table rebuild finish first, so the hold-off really backs up the block.
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         hold_go <= 1'b1;
         wait (hold_active);
         @(posedge clock);
      end
      while (sent < n_items) begin
         burst = (with_hold && sent == 0) ? 14 : $urandom_range(1, 12);
         bias  = $urandom_range(0, 1) ? alloc_pct : 100 - alloc_pct;
         for (int k = 0; k < burst && sent < n_items; k++) begin
            offer_request(pick_kind(bias), pick_id(), $urandom);
            sent++;
         end
         // Halfway through, let the block empty completely once.
         if (!paused && sent >= n_items / 2) begin
            paused = 1'b1;
            drain_results();
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // Result side: stretches of no stall, random stall and patterned stall,
   // with one long hold-off when the stimulus asks for it.
   initial begin
      int unsigned run, mode;
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_active <= 1'b1;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_active <= 1'b0;
         end
         run  = $urandom_range(4, 40);
         mode = $urandom_range(0, 3);
         for (int unsigned n = 0; n < run; n++) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 30);
               2:       rsp_stall <= (n % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 99) < 75);
            endcase
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats on the reset setting: grants, handles, double free, bad IDs.
      offer_request(KIND_ALLOC, '0, '0);
      offer_request(KIND_ALLOC, '0, '0);
      offer_request(KIND_SET, 32'd1023, 32'hFFFF_FFFF);
      offer_request(KIND_GET, 32'd1023, '0);
      offer_request(KIND_SET, 32'd1022, 32'hA5A5_5A5A);
      offer_request(KIND_GET, 32'd1, 32'hFFFF_FFFF);
      offer_request(KIND_FREE, 32'd1023, '0);
      offer_request(KIND_FREE, 32'd1023, '0);
      offer_request(KIND_FREE, 32'd1023, '0);
      offer_request(KIND_GET, 32'd1023, '0);
      offer_request(KIND_FREE, 32'd0, '0);
      offer_request(KIND_GET, 32'd0, '0);
      offer_request(KIND_SET, 32'd1024, 32'h1234_5678);
      offer_request(KIND_GET, 32'hFFFF_FFFF, '0);
      offer_request(KIND_FREE, 32'd500, '0);
      offer_request(KIND_ALLOC, '0, '0);
      offer_request(KIND_GET, 32'd1022, '0);

      // A three-slot pool whose IDs wrap past zero, run until empty.
      set_pool(32'hFFFF_FFFE, 11'd3);
      offer_request(KIND_ALLOC, '0, '0);
      offer_request(KIND_ALLOC, '0, '0);
      offer_request(KIND_ALLOC, '0, '0);
      offer_request(KIND_SET, 32'hFFFF_FFFF, 32'h0000_0001);
      offer_request(KIND_GET, 32'hFFFF_FFFF, '0);
      offer_request(KIND_GET, 32'h0000_0000, '0);
      offer_request(KIND_FREE, 32'hFFFF_FFFD, '0);
      offer_request(KIND_FREE, 32'hFFFF_FFFF, '0);
      offer_request(KIND_ALLOC, '0, '0);

      // Random part over several settings, extremes included.
      run_phase(32'h0000_1000, 11'd8, 100, 50, 1'b0);
      run_phase(32'hFFFF_FFF8, 11'd16, 100, 45, 1'b0);
      run_phase($urandom, 11'd1, 25, 50, 1'b0);
      run_phase(32'hFFFF_FFFF, 11'd0, 20, 40, 1'b0);
      run_phase($urandom, 11'd2047, 100, 65, 1'b1);
      run_phase(32'h0000_0000, 11'd3, 100, 45, 1'b0);
      run_phase($urandom, 11'd1024, 70, 40, 1'b0);

      drain_results();
      repeat (20) @(posedge clock);

      $display("Summary: %0d result beats checked over %0d register writes.",
               beats_checked, settings_seen);
      $display("Summary: %0d IDs granted, %0d allocates on an empty pool, %0d invalid IDs.",
               grants, empty_denials, invalid_ids);
      if (fail_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Overall time limit, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Timeout with %0d result beats still pending.", outstanding);
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: id_pool_allocator.f
design/idp_pkg.sv
design/idp_ram.sv
design/idp_front.sv
design/idp_cmd_queue.sv
design/idp_back.sv
design/id_pool_allocator.sv
tb/sv/idp_pool_checker.sv
tb/sv/id_pool_allocator_tb.sv
